FILE: rtl/m3i_pkg.sv
package m3i_pkg;

    localparam int EW    = 32;
    localparam int CW    = 65;
    localparam int DW    = 98;
    localparam int QW    = 32;
    localparam int NL    = 9;
    localparam int NSTEP = QW;

    localparam logic [QW-1:0] SAT_POS = {1'b0, {(QW-1){1'b1}}};
    localparam logic [QW-1:0] SAT_NEG = {1'b1, {(QW-1){1'b0}}};

    typedef logic signed [EW-1:0] elem_t;
    typedef logic signed [CW-1:0] cof_t;
    typedef logic signed [DW-1:0] det_t;

    typedef struct packed {
        elem_t a00;
        elem_t a01;
        elem_t a02;
        elem_t a10;
        elem_t a11;
        elem_t a12;
        elem_t a20;
        elem_t a21;
        elem_t a22;
    } mat_t;

    typedef struct packed {
        elem_t inv00;
        elem_t inv01;
        elem_t inv02;
        elem_t inv10;
        elem_t inv11;
        elem_t inv12;
        elem_t inv20;
        elem_t inv21;
        elem_t inv22;
        logic  singular;
        logic  saturated;
    } inv_t;

    typedef struct packed {
        logic [DW-1:0] rem;
        logic [QW-1:0] quo;
        logic          neg;
        logic          ovf;
    } lane_t;

    typedef struct packed {
        lane_t [NL-1:0] lane;
        logic [DW-1:0]  dmag;
        logic           zero;
    } div_t;

    // element indices (row * 3 + column) of p, q, r, s in p*q - r*s
    localparam logic [3:0] COF_IDX [NL][4] = '{
        '{4'd8, 4'd4, 4'd7, 4'd5},
        '{4'd7, 4'd2, 4'd8, 4'd1},
        '{4'd5, 4'd1, 4'd4, 4'd2},
        '{4'd6, 4'd5, 4'd8, 4'd3},
        '{4'd8, 4'd0, 4'd6, 4'd2},
        '{4'd3, 4'd2, 4'd5, 4'd0},
        '{4'd7, 4'd3, 4'd6, 4'd4},
        '{4'd6, 4'd1, 4'd7, 4'd0},
        '{4'd4, 4'd0, 4'd3, 4'd1}
    };

endpackage

FILE: rtl/m3i_cofactor.sv
module m3i_cofactor
    import m3i_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  valid_in,
    input  mat_t  mat,
    output logic  valid_out,
    output cof_t  cof [NL],
    output elem_t col0 [3]
);

    elem_t m [9];
    logic signed [2*EW-1:0] pp_next [NL];
    logic signed [2*EW-1:0] pq_next [NL];
    logic signed [2*EW-1:0] pp_reg [NL];
    logic signed [2*EW-1:0] pq_reg [NL];
    elem_t c0_s1_reg [3];
    elem_t c0_s2_reg [3];
    cof_t  cof_next [NL];
    cof_t  cof_reg [NL];
    logic  v1_reg;
    logic  v2_reg;

    always_comb
    begin
        m[0] = mat.a00;
        m[1] = mat.a01;
        m[2] = mat.a02;
        m[3] = mat.a10;
        m[4] = mat.a11;
        m[5] = mat.a12;
        m[6] = mat.a20;
        m[7] = mat.a21;
        m[8] = mat.a22;
        for (int k = 0; k < NL; k++)
        begin
            pp_next[k] = (2*EW)'(m[COF_IDX[k][0]]) * (2*EW)'(m[COF_IDX[k][1]]);
            pq_next[k] = (2*EW)'(m[COF_IDX[k][2]]) * (2*EW)'(m[COF_IDX[k][3]]);
        end
        for (int k = 0; k < NL; k++)
        begin
            cof_next[k] = CW'(pp_reg[k]) - CW'(pq_reg[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg    <= pp_next;
            pq_reg    <= pq_next;
            c0_s1_reg <= '{m[0], m[3], m[6]};
            c0_s2_reg <= c0_s1_reg;
            cof_reg   <= cof_next;
        end
    end

    assign valid_out = v2_reg;
    assign cof       = cof_reg;
    assign col0      = c0_s2_reg;

endmodule

FILE: rtl/m3i_det.sv
module m3i_det
    import m3i_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  valid_in,
    input  cof_t  cof_in [NL],
    input  elem_t col0 [3],
    output logic  valid_out,
    output cof_t  cof_out [NL],
    output det_t  det
);

    cof_t cof3_reg [NL];
    cof_t cof4_reg [NL];
    cof_t cof5_reg [NL];
    cof_t cof6_reg [NL];
    logic [EW-1:0]   emag_next [3];
    logic [EW-1:0]   emag_reg [3];
    logic [62:0]     cmag_next [3];
    logic [62:0]     cmag_reg [3];
    logic            neg3_reg [3];
    logic            neg4_reg [3];
    logic [2*EW-1:0] plo_next [3];
    logic [2*EW-1:0] phi_next [3];
    logic [2*EW-1:0] plo_reg [3];
    logic [2*EW-1:0] phi_reg [3];
    logic [95:0]     tmag [3];
    det_t            term_next [3];
    det_t            term_reg [3];
    det_t            det_next;
    det_t            det_reg;
    logic [3:0]      v_reg;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            emag_next[j] = col0[j][EW-1] ? EW'(-col0[j]) : EW'(col0[j]);
            cmag_next[j] = cof_in[j][CW-1] ? 63'(-cof_in[j]) : 63'(cof_in[j]);
            plo_next[j]  = 64'(emag_reg[j]) * 64'(cmag_reg[j][31:0]);
            phi_next[j]  = 64'(emag_reg[j]) * 64'(cmag_reg[j][62:32]);
            tmag[j]      = (96'(phi_reg[j]) << 32) + 96'(plo_reg[j]);
            term_next[j] = neg4_reg[j] ? -det_t'(DW'(tmag[j])) : det_t'(DW'(tmag[j]));
        end
        det_next = term_reg[0] + term_reg[1] + term_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[2:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cof3_reg <= cof_in;
            cof4_reg <= cof3_reg;
            cof5_reg <= cof4_reg;
            cof6_reg <= cof5_reg;
            emag_reg <= emag_next;
            cmag_reg <= cmag_next;
            for (int j = 0; j < 3; j++)
            begin
                neg3_reg[j] <= col0[j][EW-1] ^ cof_in[j][CW-1];
            end
            neg4_reg <= neg3_reg;
            plo_reg  <= plo_next;
            phi_reg  <= phi_next;
            term_reg <= term_next;
            det_reg  <= det_next;
        end
    end

    assign valid_out = v_reg[3];
    assign cof_out   = cof6_reg;
    assign det       = det_reg;

endmodule

FILE: rtl/m3i_div_step.sv
module m3i_div_step
    import m3i_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic valid_in,
    input  div_t d_in,
    output logic valid_out,
    output div_t d_out
);

    div_t d_next;
    div_t d_reg;
    logic v_reg;
    logic [DW:0] r2;
    logic [DW:0] dext;

    always_comb
    begin
        d_next = d_in;
        dext   = {1'b0, d_in.dmag};
        r2     = '0;
        for (int k = 0; k < NL; k++)
        begin
            r2 = {d_in.lane[k].rem, 1'b0};
            if (r2 >= dext)
            begin
                d_next.lane[k].rem = DW'(r2 - dext);
                d_next.lane[k].quo = {d_in.lane[k].quo[QW-2:0], 1'b1};
            end
            else
            begin
                d_next.lane[k].rem = DW'(r2);
                d_next.lane[k].quo = {d_in.lane[k].quo[QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign valid_out = v_reg;
    assign d_out     = d_reg;

endmodule

FILE: rtl/m3i_divider.sv
module m3i_divider
    import m3i_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic valid_in,
    input  cof_t cof [NL],
    input  det_t det,
    output logic valid_out,
    output div_t d_out
);

    div_t p7_next;
    div_t p7_reg;
    div_t p8_next;
    div_t p8_reg;
    logic v7_reg;
    logic v8_reg;
    div_t stg [NSTEP+1];
    logic vld [NSTEP+1];
    det_t cext;

    always_comb
    begin
        p7_next      = '0;
        p7_next.dmag = det[DW-1] ? DW'(-det) : DW'(det);
        p7_next.zero = (det == '0);
        cext         = '0;
        for (int k = 0; k < NL; k++)
        begin
            cext                = det_t'(cof[k]);
            p7_next.lane[k].rem = cext[DW-1] ? DW'(-cext) : DW'(cext);
            p7_next.lane[k].neg = cof[k][CW-1] ^ det[DW-1];
        end
        p8_next = p7_reg;
        for (int k = 0; k < NL; k++)
        begin
            p8_next.lane[k].ovf = (p7_reg.lane[k].rem >= p7_reg.dmag);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else if (en)
        begin
            v7_reg <= valid_in;
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p7_reg <= p7_next;
            p8_reg <= p8_next;
        end
    end

    assign stg[0] = p8_reg;
    assign vld[0] = v8_reg;

    for (genvar s = 0; s < NSTEP; s++)
    begin : g_step
        m3i_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (vld[s]),
            .d_in      (stg[s]),
            .valid_out (vld[s+1]),
            .d_out     (stg[s+1])
        );
    end

    assign valid_out = vld[NSTEP];
    assign d_out     = stg[NSTEP];

endmodule

FILE: rtl/m3i_out.sv
module m3i_out
    import m3i_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic valid_in,
    input  div_t d_in,
    output logic en,
    output logic valid,
    input  logic stall,
    output inv_t data
);

    inv_t res;
    inv_t out_reg;
    inv_t skid_reg;
    logic out_valid_reg;
    logic skid_full_reg;
    logic take;
    logic any_ovf;
    logic big;
    logic [QW-1:0] q;
    logic [QW-1:0] v [NL];

    always_comb
    begin
        any_ovf = 1'b0;
        big     = 1'b0;
        q       = '0;
        for (int k = 0; k < NL; k++)
        begin
            q   = d_in.lane[k].quo;
            big = d_in.lane[k].neg ? (q[QW-1] && (q[QW-2:0] != '0)) : q[QW-1];
            if (d_in.lane[k].ovf || big)
            begin
                v[k]    = d_in.lane[k].neg ? SAT_NEG : SAT_POS;
                any_ovf = 1'b1;
            end
            else
            begin
                v[k] = d_in.lane[k].neg ? -q : q;
            end
            if (d_in.zero)
            begin
                v[k] = '0;
            end
        end
        res.inv00     = v[0];
        res.inv01     = v[1];
        res.inv02     = v[2];
        res.inv10     = v[3];
        res.inv11     = v[4];
        res.inv12     = v[5];
        res.inv20     = v[6];
        res.inv21     = v[7];
        res.inv22     = v[8];
        res.singular  = d_in.zero;
        res.saturated = any_ovf && !d_in.zero;
    end

    assign take = out_valid_reg && !stall;
    assign en   = !skid_full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (skid_full_reg)
        begin
            if (take)
            begin
                skid_full_reg <= 1'b0;
            end
        end
        else if (valid_in)
        begin
            if (out_valid_reg && !take)
            begin
                skid_full_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_full_reg)
        begin
            if (take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (valid_in)
        begin
            if (!out_valid_reg || take)
            begin
                out_reg <= res;
            end
            else
            begin
                skid_reg <= res;
            end
        end
    end

    assign valid = out_valid_reg;
    assign data  = out_reg;

    a_skid_has_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> out_valid_reg)
        else $error("skid holds an item with the output empty");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg && !stall |=> !skid_full_reg && out_valid_reg)
        else $error("skid item not moved to output");

    a_singular_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.singular |-> !out_reg.saturated && out_reg.inv00 == '0)
        else $error("singular item carries data");

endmodule

FILE: rtl/matrix3x3_inverse_unit.sv
// 3x3 matrix inverse in signed Q16.16 by adjugate and determinant. One matrix item
// is taken every cycle while mat_stall is low. Two stages form the cofactors, four
// the determinant, two prepare the magnitudes, thirty-two form the quotient one bit
// per stage with a 98-bit restoring subtract for each of the nine elements, and one
// saturates into the output register, which a one-item skid stage backs so that
// input stall is registered.
module matrix3x3_inverse_unit
    import m3i_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic mat_valid,
    output logic mat_stall,
    input  mat_t mat,
    output logic inv_valid,
    input  logic inv_stall,
    output inv_t inv
);

    logic  en;
    logic  cof_valid;
    cof_t  cof [NL];
    elem_t col0 [3];
    logic  det_valid;
    cof_t  cof_d [NL];
    det_t  det;
    logic  div_valid;
    div_t  div_d;

    assign mat_stall = !en;

    m3i_cofactor u_cofactor (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (mat_valid),
        .mat       (mat),
        .valid_out (cof_valid),
        .cof       (cof),
        .col0      (col0)
    );

    m3i_det u_det (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (cof_valid),
        .cof_in    (cof),
        .col0      (col0),
        .valid_out (det_valid),
        .cof_out   (cof_d),
        .det       (det)
    );

    m3i_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (det_valid),
        .cof       (cof_d),
        .det       (det),
        .valid_out (div_valid),
        .d_out     (div_d)
    );

    m3i_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (div_valid),
        .d_in     (div_d),
        .en       (en),
        .valid    (inv_valid),
        .stall    (inv_stall),
        .data     (inv)
    );

endmodule
